[hw/rtl/rnue_pkg.sv]
// ----------------------------------------------------------------------------
// Reputation norm update engine package
// Shared widths, codes and word types for the reputation norm update engine.
// ----------------------------------------------------------------------------
package rnue_pkg;

  // Default number of agents the opinion store is built for.
  localparam int unsigned MAX_AGENTS_DEF = 64;

  // Fixed field widths.
  localparam int unsigned DATA_W    = 64;
  localparam int unsigned AGENT_W   = 6;
  localparam int unsigned CNT_W     = 7;
  localparam int unsigned NORM_W    = 2;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 7;

  // Assessment norms.
  typedef enum logic [NORM_W-1:0] {
    NORM_L4 = 2'd0,
    NORM_L6 = 2'd1,
    NORM_L7 = 2'd2,
    NORM_L8 = 2'd3
  } norm_e;

  // Input actions.
  typedef enum logic {
    ACT_LOAD   = 1'b0,
    ACT_UPDATE = 1'b1
  } action_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NORM_SELECT = 1'b0,
    CFG_AGENT_COUNT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic               action;
    logic [AGENT_W-1:0] row_index;
    logic [DATA_W-1:0]  row_bits;
    logic [AGENT_W-1:0] donor;
    logic [AGENT_W-1:0] recipient;
    logic [DATA_W-1:0]  flip_mask;
  } in_word_t;

  typedef struct packed {
    logic [DATA_W-1:0] donor_column;
    logic              absorbed;
  } out_word_t;

endpackage

[hw/rtl/reputation_norm_update_engine_core.sv]
// ----------------------------------------------------------------------------
// Reputation norm update engine core
// Opinion matrix store with norm-based column update and absorbing check.
// ----------------------------------------------------------------------------
// The opinion matrix is held column by column in a memory of MAX_AGENTS words
// with one write port and two registered read ports, and every item runs
// through one shared norm evaluator under a small sequencer; the block takes
// one word at a time. A load word writes one row by a read-modify-write sweep
// over every stored column, one column per cycle. An update word reads the
// donor and recipient columns and writes the new donor column, then the
// absorbing scan visits one (donor, recipient) pair per cycle over the clamped
// agent count with all observers evaluated side by side. An update whose donor
// or recipient lies outside the agent count skips the write and reports a zero
// column. Rows must be loaded before they are used; the store has no reset. A
// finished result sits in an output register, so a new word is accepted while
// it waits to be taken. Configuration words are always accepted and must only
// be sent while idle.
module reputation_norm_update_engine_core
  import rnue_pkg::*;
#(
  parameter int unsigned MAX_AGENTS = MAX_AGENTS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Input channel.
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_word_t             in_word_i,
  // Result channel.
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_word_t            out_word_o,
  // Configuration write channel.
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i
);

  localparam int unsigned W  = MAX_AGENTS;
  localparam int unsigned AW = $clog2(MAX_AGENTS);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LOAD   = 3'd1;
  localparam logic [2:0] ST_UPD_RD = 3'd2;
  localparam logic [2:0] ST_UPD_WR = 3'd3;
  localparam logic [2:0] ST_ABS    = 3'd4;
  localparam logic [2:0] ST_FIN    = 3'd5;

  // Applies the selected norm to observer vectors a and c with the scalar b.
  function automatic logic [W-1:0] norm_eval(input norm_e sel, input logic [W-1:0] a,
                                             input logic b, input logic [W-1:0] c);
    logic [W-1:0] res;
    unique case (sel)
      NORM_L4: res = b ? (a | c) : ~c;
      NORM_L6: res = b ? c : ~c;
      NORM_L7: res = b ? (a | c) : (a & ~c);
      NORM_L8: res = b ? c : (a & ~c);
      default: res = c;
    endcase
    return res;
  endfunction

  // Control state.
  logic [2:0]       state_q, state_d;
  norm_e            norm_q, norm_d;
  logic [CNT_W-1:0] agent_count_q, agent_count_d;
  logic [AW-1:0]    d_cnt_q, d_cnt_d;
  logic [AW-1:0]    r_cnt_q, r_cnt_d;
  logic             ld_v_q, chk_v_q;
  logic             abs_ok_q, abs_ok_d;
  logic             out_valid_q, out_valid_d;

  // Item payload.
  logic [AW-1:0]    row_idx_q;
  logic [W-1:0]     row_bits_q;
  logic [AW-1:0]    donor_q;
  logic [AW-1:0]    recip_q;
  logic [W-1:0]     flip_q;
  logic [W-1:0]     col_q;
  out_word_t        out_word_q;

  // Column memory: col_mem[j] bit o holds the opinion of observer o about agent j.
  logic [W-1:0]     col_mem [MAX_AGENTS];
  logic [AW-1:0]    rd_addr_a, rd_addr_b;
  logic [W-1:0]     rd_a_q, rd_b_q;
  logic [AW-1:0]    a_addr_q;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [W-1:0]     mem_wdata;

  logic [CNT_W-1:0] n_eff;
  logic [W-1:0]     lane_mask;
  logic [W-1:0]     eval_v;
  logic [W-1:0]     new_col;
  logic             violation;
  logic             accept;
  logic             row_in_range;
  logic             pair_in_range;
  logic             d_last, r_last;
  logic             fin_go;

  // Agent count clamped to the built range, and the observer lanes it covers.
  always_comb begin
    if (agent_count_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (agent_count_q > CNT_W'(MAX_AGENTS)) begin
      n_eff = CNT_W'(MAX_AGENTS);
    end else begin
      n_eff = agent_count_q;
    end
    for (int o = 0; o < W; o++) begin
      lane_mask[o] = (CNT_W'(o) < n_eff);
    end
  end

  assign accept        = in_valid_i && !in_stall_o;
  assign row_in_range  = CNT_W'(in_word_i.row_index) < CNT_W'(MAX_AGENTS);
  assign pair_in_range = (CNT_W'(in_word_i.donor) < n_eff) &&
                         (CNT_W'(in_word_i.recipient) < n_eff);
  assign d_last        = CNT_W'(d_cnt_q) == (n_eff - CNT_W'(1));
  assign r_last        = CNT_W'(r_cnt_q) == (n_eff - CNT_W'(1));

  // The one shared evaluator. Port A carries the donor column, port B the
  // recipient column, and the donor's opinion of the recipient is bit d of B.
  assign eval_v    = norm_eval(norm_q, rd_a_q, rd_b_q[a_addr_q], rd_b_q);
  assign new_col   = (eval_v ^ flip_q) & lane_mask;
  assign violation = |((eval_v ^ rd_a_q) & lane_mask);

  // Read address selection.
  always_comb begin
    unique case (state_q)
      ST_LOAD: begin
        rd_addr_a = d_cnt_q;
        rd_addr_b = d_cnt_q;
      end
      ST_UPD_RD: begin
        rd_addr_a = donor_q;
        rd_addr_b = recip_q;
      end
      default: begin
        rd_addr_a = d_cnt_q;
        rd_addr_b = r_cnt_q;
      end
    endcase
  end

  // Write port: the load sweep writes back one column with the loaded row's
  // bit replaced, and an update writes the new donor column, in which lanes at
  // and above the agent count keep their stored value.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = a_addr_q;
    mem_wdata = rd_a_q;
    if (ld_v_q) begin
      mem_we               = 1'b1;
      mem_wdata[row_idx_q] = row_bits_q[a_addr_q];
    end else if (state_q == ST_UPD_WR) begin
      mem_we    = 1'b1;
      mem_waddr = donor_q;
      mem_wdata = new_col | (rd_a_q & ~lane_mask);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      col_mem[mem_waddr] <= mem_wdata;
    end
    rd_a_q   <= col_mem[rd_addr_a];
    rd_b_q   <= col_mem[rd_addr_b];
    a_addr_q <= rd_addr_a;
  end

  assign fin_go = (state_q == ST_FIN) && !chk_v_q && (!out_valid_q || !out_stall_i);

  // Sequencer.
  always_comb begin
    state_d       = state_q;
    norm_d        = norm_q;
    agent_count_d = agent_count_q;
    d_cnt_d       = d_cnt_q;
    r_cnt_d       = r_cnt_q;
    abs_ok_d      = abs_ok_q;
    out_valid_d   = out_valid_q;

    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_NORM_SELECT: norm_d        = norm_e'(cfg_data_i[NORM_W-1:0]);
        CFG_AGENT_COUNT: agent_count_d = cfg_data_i;
        default:         norm_d        = norm_q;
      endcase
    end

    if (chk_v_q && violation) begin
      abs_ok_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          d_cnt_d  = '0;
          r_cnt_d  = '0;
          abs_ok_d = 1'b1;
          if (action_e'(in_word_i.action) == ACT_LOAD) begin
            if (row_in_range) begin
              state_d = ST_LOAD;
            end
          end else if (pair_in_range) begin
            state_d = ST_UPD_RD;
          end else begin
            state_d = ST_ABS;
          end
        end
      end
      ST_LOAD: begin
        d_cnt_d = d_cnt_q + AW'(1);
        if (d_cnt_q == AW'(MAX_AGENTS - 1)) begin
          d_cnt_d = '0;
          state_d = ST_IDLE;
        end
      end
      ST_UPD_RD: begin
        state_d = ST_UPD_WR;
      end
      ST_UPD_WR: begin
        state_d = ST_ABS;
      end
      ST_ABS: begin
        if (r_last) begin
          r_cnt_d = '0;
          d_cnt_d = d_cnt_q + AW'(1);
          if (d_last) begin
            d_cnt_d = '0;
            state_d = ST_FIN;
          end
        end else begin
          r_cnt_d = r_cnt_q + AW'(1);
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (fin_go) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      norm_q        <= NORM_L4;
      agent_count_q <= CNT_W'(64);
      d_cnt_q       <= '0;
      r_cnt_q       <= '0;
      ld_v_q        <= 1'b0;
      chk_v_q       <= 1'b0;
      abs_ok_q      <= 1'b1;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      norm_q        <= norm_d;
      agent_count_q <= agent_count_d;
      d_cnt_q       <= d_cnt_d;
      r_cnt_q       <= r_cnt_d;
      ld_v_q        <= (state_q == ST_LOAD);
      chk_v_q       <= (state_q == ST_ABS);
      abs_ok_q      <= abs_ok_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      row_idx_q  <= in_word_i.row_index[AW-1:0];
      row_bits_q <= in_word_i.row_bits[W-1:0];
      donor_q    <= in_word_i.donor[AW-1:0];
      recip_q    <= in_word_i.recipient[AW-1:0];
      flip_q     <= in_word_i.flip_mask[W-1:0];
      col_q      <= '0;
    end else if (state_q == ST_UPD_WR) begin
      col_q <= new_col;
    end
    if (fin_go) begin
      out_word_q.donor_column <= DATA_W'(col_q);
      out_word_q.absorbed     <= abs_ok_q;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;
  assign cfg_ready_o = 1'b1;

endmodule

[verif/rnue_opinion_checker.sv]
// ----------------------------------------------------------------------------
// Opinion matrix checker
// Watches the input, result and configuration channels of the reputation norm
// update engine, keeps its own copy of the opinion matrix and settings, works
// out the result of every update word and compares it with what comes out.
// ----------------------------------------------------------------------------
module rnue_opinion_checker
  import rnue_pkg::*;
#(
  parameter int unsigned MAX_AGENTS = MAX_AGENTS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  in_word_t             in_word_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  out_word_t            out_word_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  output int unsigned          fault_count_o,
  output int unsigned          pending_o
);

  logic [DATA_W-1:0] opinion_store [MAX_AGENTS];
  norm_e             norm_q;
  logic [CNT_W-1:0]  count_q;
  out_word_t         pending_results [$];

  initial begin
    fault_count_o = 0;
    pending_o     = 0;
  end

  function automatic int unsigned clamp_agents(input logic [CNT_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > MAX_AGENTS) return MAX_AGENTS;
    return 32'(raw);
  endfunction

  function automatic logic [DATA_W-1:0] agent_mask(input int unsigned n);
    return (n >= DATA_W) ? {DATA_W{1'b1}} : ((64'd1 << n) - 64'd1);
  endfunction

  function automatic logic [DATA_W-1:0] assess(input norm_e norm,
                                               input logic [DATA_W-1:0] a,
                                               input logic b,
                                               input logic [DATA_W-1:0] c);
    case (norm)
      NORM_L4: return b ? (a | c) : ~c;
      NORM_L6: return b ? c : ~c;
      NORM_L7: return b ? (a | c) : (a & ~c);
      default: return b ? c : (a & ~c);
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] column(input int unsigned j, input int unsigned n);
    logic [DATA_W-1:0] col;
    col = '0;
    for (int unsigned i = 0; i < n; i++) col[i] = opinion_store[i][j];
    return col;
  endfunction

  // The matrix is absorbing when no error-free assessment of any pair moves
  // any observer's opinion.
  function automatic logic matrix_absorbed(input int unsigned n);
    logic [DATA_W-1:0] cols [MAX_AGENTS];
    logic [DATA_W-1:0] lanes;
    lanes = agent_mask(n);
    for (int unsigned d = 0; d < n; d++) cols[d] = column(d, n);
    for (int unsigned d = 0; d < n; d++) begin
      for (int unsigned r = 0; r < n; r++) begin
        if (((assess(norm_q, cols[d], opinion_store[d][r], cols[r]) ^ cols[d]) & lanes) != '0)
          return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Rewrites the donor column and returns the result word it should cause.
  function automatic out_word_t apply_update(input in_word_t w);
    out_word_t         res;
    int unsigned       n;
    int unsigned       d;
    int unsigned       r;
    logic [DATA_W-1:0] fresh;
    n   = clamp_agents(count_q);
    d   = 32'(w.donor);
    r   = 32'(w.recipient);
    res = '0;
    if (d < n && r < n) begin
      fresh = (assess(norm_q, column(d, n), opinion_store[d][r], column(r, n)) ^ w.flip_mask)
              & agent_mask(n);
      for (int unsigned o = 0; o < n; o++) opinion_store[o][d] = fresh[o];
      res.donor_column = fresh;
    end
    res.absorbed = matrix_absorbed(n);
    return res;
  endfunction

  task automatic report_fault(input string msg);
    if (fault_count_o < 10) $display("%0t: %s", $realtime, msg);
    fault_count_o++;
  endtask

  // Results are checked before new words are predicted, since a result that
  // leaves at an edge can never belong to a word taken at that same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    out_word_t predicted;
    if (!rst_ni) begin
      norm_q  = NORM_L4;
      count_q = CNT_W'(MAX_AGENTS);
      pending_results.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_NORM_SELECT: norm_q = norm_e'(cfg_data_i[NORM_W-1:0]);
          CFG_AGENT_COUNT: count_q = cfg_data_i[CNT_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          report_fault($sformatf("unexpected result word: column %h absorbed %b",
                                 out_word_i.donor_column, out_word_i.absorbed));
        end else begin
          want = pending_results.pop_front();
          if (out_word_i.donor_column !== want.donor_column ||
              out_word_i.absorbed !== want.absorbed) begin
            report_fault($sformatf("result mismatch: column %h/%h absorbed %b/%b (exp/got)",
                                   want.donor_column, out_word_i.donor_column,
                                   want.absorbed, out_word_i.absorbed));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (in_word_i.action == ACT_UPDATE) begin
          predicted       = apply_update(in_word_i);
          pending_results = {pending_results, predicted};
        end else if (in_word_i.row_index < MAX_AGENTS) begin
          opinion_store[in_word_i.row_index] = in_word_i.row_bits;
        end
      end
    end
    pending_o = pending_results.size();
  end

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// Reputation norm update engine testbench
// Preloads the whole opinion matrix, runs a directed set of load and update
// words over every norm and the agent count extremes, then random phases with
// varying idling on both channels and one long result hold-off. A checker
// module beside the engine predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb;
  import rnue_pkg::*;

  localparam int unsigned MAX_AGENTS = MAX_AGENTS_DEF;
  // A load word keeps the engine busy for a sweep over every column with no result
  // to show for it, so idle checks wait out LOAD_SETTLE, which outlasts the sweep.
  localparam int unsigned LOAD_SETTLE = MAX_AGENTS + 16;
  localparam int unsigned DRAIN_LIMIT = 20000;
  localparam int unsigned RECV_HOLD_CYCLES = 3000;
  localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_word_t             in_word;
  logic                 out_valid;
  logic                 out_stall;
  out_word_t            out_word;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;
  int unsigned          fault_count;
  int unsigned          pending_count;

  // Idling odds in percent, set per phase by the stimulus process.
  int unsigned send_idle_pct = 37;
  int unsigned recv_idle_pct = 88;
  bit          hold_request  = 1'b0;

  reputation_norm_update_engine_core #(
    .MAX_AGENTS(MAX_AGENTS)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  rnue_opinion_checker #(
    .MAX_AGENTS(MAX_AGENTS)
  ) i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_word_i    (in_word),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_word_i   (out_word),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fault_count_o(fault_count),
    .pending_o    (pending_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // The whole run is bounded here; the slowest correct run is far shorter.
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Result side. It stalls at random at the odds of the current phase, and once
  // on request it holds off for a long stretch so that the engine backs up.
  initial begin
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        hold_left = RECV_HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  function automatic logic [DATA_W-1:0] rand_bits64();
    return {$urandom, $urandom};
  endfunction

  // Random word for n agents in use. Donors, recipients and loaded rows mostly
  // fall inside the agent count; some land outside it. Error-free updates and
  // all-ones rows are common so that absorbing matrices show up now and then.
  function automatic in_word_t rand_word(input int unsigned n);
    in_word_t w;
    w.action    = ($urandom_range(99) < 40) ? ACT_LOAD : ACT_UPDATE;
    w.row_index = ($urandom_range(9) < 7) ? AGENT_W'($urandom_range(n - 1))
                                          : AGENT_W'($urandom_range(MAX_AGENTS - 1));
    case ($urandom_range(7))
      0: w.row_bits = ALL_ONES;
      1: w.row_bits = '0;
      default: w.row_bits = rand_bits64();
    endcase
    w.donor     = ($urandom_range(9) == 0) ? AGENT_W'($urandom)
                                           : AGENT_W'($urandom_range(n - 1));
    w.recipient = ($urandom_range(9) == 0) ? AGENT_W'($urandom)
                                           : AGENT_W'($urandom_range(n - 1));
    case ($urandom_range(9))
      0, 1, 2, 3, 4: w.flip_mask = '0;
      5, 6: w.flip_mask = 64'd1 << $urandom_range(DATA_W - 1);
      default: w.flip_mask = rand_bits64();
    endcase
    return w;
  endfunction

  function automatic in_word_t load_word(input int unsigned row,
                                         input logic [DATA_W-1:0] bits);
    in_word_t w;
    w           = rand_word(MAX_AGENTS);
    w.action    = ACT_LOAD;
    w.row_index = AGENT_W'(row);
    w.row_bits  = bits;
    return w;
  endfunction

  function automatic in_word_t update_word(input int unsigned d, input int unsigned r,
                                           input logic [DATA_W-1:0] flips);
    in_word_t w;
    w           = rand_word(MAX_AGENTS);
    w.action    = ACT_UPDATE;
    w.donor     = AGENT_W'(d);
    w.recipient = AGENT_W'(r);
    w.flip_mask = flips;
    return w;
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is
  // taken, with valid still high so back-to-back words need no gap.
  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_word  = w;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DAT_W-1:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Registers change only once every result is out and any trailing load word
  // has had time to finish its sweep.
  task automatic configure(input norm_e norm, input logic [CFG_DAT_W-1:0] count);
    in_valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (LOAD_SETTLE) @(negedge clk);
    write_reg(CFG_NORM_SELECT, CFG_DAT_W'(norm));
    write_reg(CFG_AGENT_COUNT, count);
  endtask

  task automatic run_random(input norm_e norm, input int unsigned n, input int unsigned words,
                            input int unsigned send_pct, input int unsigned recv_pct,
                            input bit hold);
    configure(norm, CFG_DAT_W'(n));
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    hold_request  = hold;
    repeat (words) send_word(rand_word(n));
  endtask

  initial begin
    int unsigned guard;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_word   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_NORM_SELECT;
    cfg_data  = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Every row is written before any update reads the matrix, and since rows
    // are never lost, later changes of the agent count stay safe.
    configure(NORM_L4, CFG_DAT_W'(MAX_AGENTS));
    for (int unsigned i = 0; i < MAX_AGENTS; i++) begin
      send_word(load_word(i, (i == 0) ? ALL_ONES : (i == 1) ? '0 : rand_bits64()));
    end

    // Directed part at the full agent count: corner donors and recipients,
    // no errors, errors everywhere, and errors on the edge observers only.
    send_word(update_word(0, 0, '0));
    send_word(update_word(MAX_AGENTS - 1, MAX_AGENTS - 1, ALL_ONES));
    send_word(update_word(MAX_AGENTS - 1, 0, (64'd1 << 63) | 64'd1));

    // An agent count of zero acts as a single agent. An all-ones single entry
    // is absorbing; donors or recipients past the count leave the matrix alone
    // and report a zero column.
    configure(NORM_L8, '0);
    send_word(load_word(0, ALL_ONES));
    send_word(update_word(0, 0, '0));
    send_word(update_word(1, 0, rand_bits64()));
    send_word(update_word(0, MAX_AGENTS - 1, rand_bits64()));
    send_word(load_word(0, '0));
    send_word(update_word(0, 0, '0));

    // Three agents of all-ones opinions are absorbing; flipping every observer
    // then breaks that.
    configure(NORM_L7, CFG_DAT_W'(3));
    for (int unsigned i = 0; i < 3; i++) send_word(load_word(i, ALL_ONES));
    send_word(update_word(2, 1, '0));
    send_word(update_word(2, 2, ALL_ONES));
    send_word(update_word(5, 5, rand_bits64()));

    // An oversized count is clamped to the full matrix.
    configure(NORM_L6, {CFG_DAT_W{1'b1}});
    send_word(update_word(31, 32, rand_bits64()));

    // Random phases. Small agent counts keep the absorbing scan short; one
    // phase runs the full matrix with few words.
    run_random(NORM_L4, 5, 10, 37, 88, 1'b0);
    run_random(NORM_L6, 16, 10, 37, 88, 1'b0);
    run_random(NORM_L7, 2, 10, 88, 37, 1'b0);
    run_random(NORM_L8, MAX_AGENTS, 6, 88, 37, 1'b0);
    run_random(norm_e'($urandom_range(3)), 1, 4, 0, 0, 1'b0);
    run_random(norm_e'($urandom_range(3)), 8, 20, 0, 0, 1'b1);

    in_valid = 1'b0;
    guard    = 0;
    while (pending_count != 0 && guard < DRAIN_LIMIT) begin
      @(negedge clk);
      guard++;
    end
    repeat (LOAD_SETTLE) @(negedge clk);
    if (fault_count == 0 && pending_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
